@@ design/bounded_lifo_stack_with_search_core_macros.svh @@
// Assertion macros for the stack core RTL (included by blsws_ctrl).
// Clocked on clk, disabled while rst_n is low; no other dependencies.
`ifndef BOUNDED_LIFO_STACK_WITH_SEARCH_CORE_MACROS_SVH
`define BOUNDED_LIFO_STACK_WITH_SEARCH_CORE_MACROS_SVH

// condition holds at every edge
`define BLSWS_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define BLSWS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BLSWS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/blsws_pkg.sv @@
// Types and constants for the bounded LIFO stack core.
// No dependencies; imported by every module of the block.
package blsws_pkg;

  localparam int REQ_W  = 3;
  localparam int DATA_W = 32;
  localparam int POS_W  = 4;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 5;

  localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_TOP    = 3'd2,
    REQ_CLEAR  = 3'd3,
    REQ_SEARCH = 3'd4
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_READ = 2'd2,
    S_CMP  = 2'd3
  } state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic [POS_W-1:0]         position;
    status_t                  status;
    logic [CNT_W-1:0]         count;
    logic                     is_full;
    logic                     is_empty;
  } result_t;

endpackage

@@ design/blsws_mem.sv @@
// Stack storage: one write port, one read port with registered read data.
// Depends on blsws_pkg for the word width.
module blsws_mem
  import blsws_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/blsws_ctrl.sv @@
// Request sequencer: fill count, scan pointer and the single word comparator.
// Depends on blsws_pkg and the assertion macro header; drives blsws_mem.
`include "bounded_lifo_stack_with_search_core_macros.svh"

module blsws_ctrl
  import blsws_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  req_t              in_req,
  input  logic [DATA_W-1:0] in_value,
  input  logic              out_free,
  output logic              res_valid,
  output result_t           res,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [DATA_W-1:0] wr_data,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  logic [DATA_W-1:0] rd_data
);

  state_t            state_r, state_nxt;
  req_t              req_r, req_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     dist_r, dist_nxt;
  logic [CW-1:0]     scan_idx;
  logic              hit;
  logic              last;
  logic              done;

  // entry under the scan pointer, counted down from the top
  assign scan_idx = cnt_r - CW'(1) - CW'(dist_r);
  assign hit      = (rd_data == val_r);
  assign last     = ((CW'(dist_r) + CW'(1)) == cnt_r);

  assign wr_addr = cnt_r[AW-1:0];
  assign wr_data = val_r;
  assign rd_addr = scan_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    val_r  <= val_nxt;
    dist_r <= dist_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    val_nxt      = val_r;
    cnt_nxt      = cnt_r;
    dist_nxt     = dist_r;
    in_ready     = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    done         = 1'b0;
    res.data_out = '0;
    res.position = '0;
    res.status   = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt   = in_req;
          val_nxt   = in_value;
          dist_nxt  = '0;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (req_r)
          REQ_PUSH: begin
            done = 1'b1;
            if (cnt_r == CW'(DEPTH)) begin
              res.status = ST_OVERFLOW;
            end else if (out_free) begin
              wr_en   = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          REQ_POP: begin
            done = 1'b1;
            if (cnt_r == '0) begin
              res.status = ST_EMPTY;
            end else if (out_free) begin
              cnt_nxt = cnt_r - CW'(1);
            end
          end
          REQ_CLEAR: begin
            done = 1'b1;
            if (out_free) begin
              cnt_nxt = '0;
            end
          end
          REQ_TOP: begin
            if (cnt_r == '0) begin
              done         = 1'b1;
              res.data_out = MOST_NEG;
              res.status   = ST_EMPTY;
            end else begin
              state_nxt = S_READ;
            end
          end
          REQ_SEARCH: begin
            if (cnt_r == '0) begin
              done       = 1'b1;
              res.status = ST_NOTFOUND;
            end else begin
              state_nxt = S_READ;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end

      S_READ: begin
        rd_en     = 1'b1;
        state_nxt = S_CMP;
      end

      S_CMP: begin
        if (req_r == REQ_TOP) begin
          done         = 1'b1;
          res.data_out = rd_data;
        end else if (hit) begin
          done         = 1'b1;
          res.position = POS_W'(dist_r);
        end else if (last) begin
          done       = 1'b1;
          res.status = ST_NOTFOUND;
        end else begin
          dist_nxt  = dist_r + AW'(1);
          state_nxt = S_READ;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // result leaves only when the output register can take it
    res_valid = done && out_free;
    if (res_valid) begin
      state_nxt = S_IDLE;
    end

    res.count    = CNT_W'(cnt_nxt);
    res.is_full  = (cnt_nxt == CW'(DEPTH));
    res.is_empty = (cnt_nxt == '0);
  end

  `BLSWS_ASSERT_NOW(a_cnt_bound, cnt_r <= CW'(DEPTH), "fill count above depth")
  `BLSWS_ASSERT_NXT(a_push_grows, wr_en, cnt_r == $past(cnt_r) + CW'(1), "push lost count")
  `BLSWS_ASSERT_IMP(a_scan_range, state_r == S_CMP, CW'(dist_r) < cnt_r, "scan past bottom")
  `BLSWS_ASSERT_NXT(a_one_busy, in_valid && in_ready, !in_ready, "second word taken while busy")

endmodule

@@ design/bounded_lifo_stack_with_search_core.sv @@
// Bounded LIFO stack with search.
// Channels: in_* (request word in), out_* (one result word per request).
// Each accepted request gives exactly one result word.
// Steps: push, pop, clear and unused codes, and read top or search on an
// empty stack, finish in the exec state; read top runs exec, read and
// compare; search runs exec, then a read and a compare for each entry,
// from the top down to the match or the bottom of the stack.
// One request is in work at a time: in_tready is high only while the
// sequencer is idle, so a new request is taken only after the last one is done.
// The search rate is set by the single comparator and the memory read
// port, each entry costing a read step and a compare step.
// The result sits in an output register; a new request is accepted while it
// waits. If out_tready stays low, the next request holds in its last step
// (state unchanged) until the register frees.
// Reset (rst_n low, synchronous) empties the stack and drops any pending
// result; stored words are not cleared and are never read before a push.
// Depends on blsws_pkg, blsws_ctrl and blsws_mem.
module bounded_lifo_stack_with_search_core
  import blsws_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [2:0]  in_tuser,   // [2:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [31:0] data_out, [35:32] position,
                                  // [37:36] status, [42:38] count,
                                  // [43] is_full, [44] is_empty, [47:45] zero
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic              out_valid_r;
  result_t           out_res_r;
  logic              out_free;
  logic              res_valid;
  result_t           res;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;

  assign out_free = !out_valid_r || out_tready;

  blsws_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (req_t'(in_tuser)),
    .in_value  (in_tdata),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  blsws_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000,
                       out_res_r.is_empty,
                       out_res_r.is_full,
                       out_res_r.count,
                       out_res_r.status,
                       out_res_r.position,
                       out_res_r.data_out};

endmodule

@@ tb/sv/bounded_lifo_stack_with_search_core_test.sv @@
// Self-checking bench for bounded_lifo_stack_with_search_core: a directed run and
// weighted random request streams, checked against a stack model kept in the bench.
// Depends on blsws_pkg and the core RTL only.
module bounded_lifo_stack_with_search_core_test
  import blsws_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH     = 16;
  localparam int HOLD_LEN  = 300;
  localparam int TAIL_WAIT = 60;
  localparam int LIMIT     = 400000;

  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

  typedef enum logic [1:0] {
    ACT_WORD  = 2'd0,
    ACT_DRAIN = 2'd1,   // sender waits until every result is back
    ACT_HOLD  = 2'd2    // receiver stops taking results for a while
  } act_t;

  typedef struct {
    act_t               act;
    logic [REQ_W-1:0]   req;
    logic [DATA_W-1:0]  value;
  } req_word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [31:0]        in_tdata = '0;
  logic [2:0]         in_tuser = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [47:0]        out_tdata;

  req_word_t          req_words[$];
  result_t            pending_results[$];

  // stack model
  logic [DATA_W-1:0]  model_mem[DEPTH];
  int                 model_fill = 0;

  int                 total_words;
  int                 words_sent = 0;
  int                 idle_phase = 0;
  int                 hold_ask = 0;
  int                 n_errors = 0;
  int                 cycles = 0;

  logic [DATA_W-1:0]  value_pool[8];

  bounded_lifo_stack_with_search_core #(.DEPTH(DEPTH)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  function automatic result_t stack_predict(logic [REQ_W-1:0] req, logic [DATA_W-1:0] value);
    result_t r;
    int      d;
    bit      found;
    r = '0;
    r.status = ST_OK;
    case (req)
      REQ_PUSH: begin
        if (model_fill >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          model_mem[model_fill] = value;
          model_fill++;
        end
      end
      REQ_POP: begin
        if (model_fill == 0) r.status = ST_EMPTY;
        else model_fill--;
      end
      REQ_TOP: begin
        if (model_fill == 0) begin
          r.data_out = MOST_NEG;
          r.status   = ST_EMPTY;
        end else begin
          r.data_out = model_mem[model_fill-1];
        end
      end
      REQ_CLEAR: model_fill = 0;
      REQ_SEARCH: begin
        found = 1'b0;
        for (d = 0; d < model_fill; d++) begin
          if (model_mem[model_fill-1-d] == value) begin
            found = 1'b1;
            break;
          end
        end
        if (found) r.position = d[POS_W-1:0];
        else r.status = ST_NOTFOUND;
      end
      default: ;
    endcase
    r.count    = model_fill[CNT_W-1:0];
    r.is_full  = (model_fill == DEPTH);
    r.is_empty = (model_fill == 0);
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(99) < 60) return value_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  task automatic add_word(logic [REQ_W-1:0] req, logic [DATA_W-1:0] value);
    req_word_t w;
    w.act   = ACT_WORD;
    w.req   = req;
    w.value = value;
    req_words.push_back(w);
  endtask

  task automatic add_act(act_t act);
    req_word_t w;
    w.act   = act;
    w.req   = REQ_PUSH;
    w.value = '0;
    req_words.push_back(w);
  endtask

  // driver: predicts at the accepting edge, then offers the next word
  always @(posedge clk) begin
    req_word_t w;
    logic      next_valid;
    int        tx_idle;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      next_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        pending_results.push_back(stack_predict(in_tuser, in_tdata));
        words_sent++;
        idle_phase <= (words_sent * 3) / total_words;
        next_valid = 1'b0;
      end
      tx_idle = (idle_phase == 0) ? 10 : (idle_phase == 1) ? 52 : 0;
      if (!next_valid && req_words.size() > 0) begin
        w = req_words[0];
        case (w.act)
          ACT_DRAIN: begin
            if (pending_results.size() == 0) void'(req_words.pop_front());
          end
          ACT_HOLD: begin
            hold_ask <= hold_ask + 1;
            void'(req_words.pop_front());
          end
          default: begin
            if ($urandom_range(99) >= tx_idle) begin
              in_tuser <= w.req;
              in_tdata <= w.value;
              next_valid = 1'b1;
              void'(req_words.pop_front());
            end
          end
        endcase
      end
      in_tvalid <= next_valid;
    end
  end

  // monitor: checks each result word and drives out_tready
  always @(posedge clk) begin
    result_t exp_r;
    result_t got;
    int      hold_seen;
    int      hold_left;
    int      rx_idle;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_seen = 0;
      hold_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.data_out = out_tdata[31:0];
        got.position = out_tdata[35:32];
        got.status   = status_t'(out_tdata[37:36]);
        got.count    = out_tdata[42:38];
        got.is_full  = out_tdata[43];
        got.is_empty = out_tdata[44];
        if (pending_results.size() == 0) begin
          $error("unexpected result word: %h", out_tdata);
          n_errors++;
        end else begin
          exp_r = pending_results.pop_front();
          if (got.data_out !== exp_r.data_out) begin
            $error("data_out expected %0d got %0d", exp_r.data_out, got.data_out);
            n_errors++;
          end
          if (got.position !== exp_r.position) begin
            $error("position expected %0d got %0d", exp_r.position, got.position);
            n_errors++;
          end
          if (got.status !== exp_r.status) begin
            $error("status expected %0d got %0d", exp_r.status, got.status);
            n_errors++;
          end
          if (got.count !== exp_r.count) begin
            $error("count expected %0d got %0d", exp_r.count, got.count);
            n_errors++;
          end
          if (got.is_full !== exp_r.is_full) begin
            $error("is_full expected %0d got %0d", exp_r.is_full, got.is_full);
            n_errors++;
          end
          if (got.is_empty !== exp_r.is_empty) begin
            $error("is_empty expected %0d got %0d", exp_r.is_empty, got.is_empty);
            n_errors++;
          end
        end
      end
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        hold_left = HOLD_LEN;
      end
      rx_idle = (idle_phase == 0) ? 52 : (idle_phase == 1) ? 10 : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int i;
    int blk;
    int mode;
    int r;
    int push_pct;
    int pop_pct;
    logic [REQ_W-1:0] req;

    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    value_pool[4] = 32'h0000_0001;
    value_pool[5] = 32'h5a5a_5a5a;
    value_pool[6] = 32'ha5a5_a5a5;
    value_pool[7] = 32'h0000_0007;

    // empty-stack corners and unused codes
    add_word(REQ_TOP, 32'h0);
    add_word(REQ_POP, 32'h0);
    add_word(REQ_SEARCH, 32'h0);
    add_word(REQ_CLEAR, 32'h0);
    add_word(REQ_UNUSED_LO, 32'hffff_ffff);
    add_word(REQ_UNUSED_HI, 32'hffff_ffff);
    // extremes, then fill past full
    add_word(REQ_PUSH, 32'h8000_0000);
    add_word(REQ_PUSH, 32'h7fff_ffff);
    add_word(REQ_PUSH, 32'hffff_ffff);
    add_word(REQ_PUSH, 32'h0);
    add_word(REQ_TOP, 32'h0);
    add_word(REQ_SEARCH, 32'h8000_0000);
    add_word(REQ_SEARCH, 32'h1234_5678);
    for (i = 4; i < DEPTH; i++) add_word(REQ_PUSH, 32'h100 + i);
    add_word(REQ_PUSH, 32'hdead_beef);
    add_word(REQ_SEARCH, 32'h8000_0000);
    add_word(REQ_POP, 32'h0);
    add_word(REQ_CLEAR, 32'h0);

    // random blocks, each leaning toward pushes, pops or neither
    for (blk = 0; blk < 30; blk++) begin
      if (blk == 10) add_act(ACT_HOLD);
      if (blk == 20) add_act(ACT_DRAIN);
      mode = $urandom_range(2);
      push_pct = (mode == 1) ? 55 : (mode == 2) ? 15 : 32;
      pop_pct  = (mode == 1) ? 10 : (mode == 2) ? 45 : 25;
      for (i = 0; i < 30; i++) begin
        r = $urandom_range(99);
        if (r < push_pct) req = REQ_PUSH;
        else if (r < push_pct + pop_pct) req = REQ_POP;
        else if (r < push_pct + pop_pct + 12) req = REQ_TOP;
        else if (r < push_pct + pop_pct + 14) req = REQ_CLEAR;
        else if (r < push_pct + pop_pct + 18)
          req = REQ_UNUSED_LO + REQ_W'($urandom_range(2));
        else req = REQ_SEARCH;
        add_word(req, pick_value());
      end
    end
    total_words = req_words.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (req_words.size() > 0 || in_tvalid) @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
